[rtl/encoder_pid_motor_controller_assert.svh]
// ============================================================================
// Assertion macros for the encoder PID motor controller
// Shared concurrent assertion forms used by the RTL modules.
// ============================================================================
`ifndef ENCODER_PID_MOTOR_CONTROLLER_ASSERT_SVH
`define ENCODER_PID_MOTOR_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define EPMC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define EPMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/epmc_pkg.sv]
// ============================================================================
// Encoder PID motor controller package
// Widths, codes, shared structs and the drive clamp.
// ============================================================================
package epmc_pkg;

    // Field and datapath widths
    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 8;
    localparam int MIN_W     = 8;
    localparam int GOAL_W    = 16;
    localparam int VEL_W     = 16;
    localparam int VERR_W    = VEL_W + GAIN_FRAC;
    localparam int PERR_W    = 32;
    localparam int POSC_W    = 32;
    localparam int PROD_W    = PERR_W + GAIN_W;
    localparam int FRAC_W    = 16;
    localparam int SUM_W     = PROD_W + GAIN_FRAC + 2;
    localparam int INT_W     = 18;
    localparam int DUTY_W    = 8;
    localparam int LIM_W     = 16;
    localparam int REG_IDX_W = 3;
    localparam int ADDR_W    = REG_IDX_W + 2;
    localparam int DATA_W    = 32;

    // Item kinds
    typedef enum logic {
        CMD_EDGE = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    // Register map, one word per register
    typedef enum logic [REG_IDX_W-1:0] {
        REG_VEL_KP  = 3'd0,
        REG_VEL_KI  = 3'd1,
        REG_VEL_KD  = 3'd2,
        REG_POS_KP  = 3'd3,
        REG_POS_KI  = 3'd4,
        REG_POS_KD  = 3'd5,
        REG_MIN_FWD = 3'd6,
        REG_MIN_REV = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] vel_kp;
        logic [GAIN_W-1:0] vel_ki;
        logic [GAIN_W-1:0] vel_kd;
        logic [GAIN_W-1:0] pos_kp;
        logic [GAIN_W-1:0] pos_ki;
        logic [GAIN_W-1:0] pos_kd;
        logic [MIN_W-1:0]  min_fwd;
        logic [MIN_W-1:0]  min_rev;
    } t_cfg;

    // Tick beat from the encoder stage to the PID pipeline
    typedef struct packed {
        logic                     hold;
        logic signed [GOAL_W-1:0] goal;
        logic signed [VEL_W-1:0]  meas;
        logic signed [PERR_W-1:0] perr;
        logic [POSC_W-1:0]        pos_count;
    } t_meas;

    // Result beat
    typedef struct packed {
        logic [DUTY_W-1:0]       fwd;
        logic [DUTY_W-1:0]       rev;
        logic signed [VEL_W-1:0] meas;
        logic [POSC_W-1:0]       pos_count;
        logic                    hold;
    } t_result;

    // Limit a Q.16 value to +-lim, lift small values to the minimum drive,
    // otherwise truncate toward zero to an integer duty.
    function automatic logic signed [INT_W-1:0] clamp_drive(
        input logic signed [SUM_W-1:0] v,
        input logic [LIM_W-1:0]        lim,
        input logic [MIN_W-1:0]        mf,
        input logic [MIN_W-1:0]        mr
    );
        logic signed [SUM_W-1:0] lim_q;
        logic signed [SUM_W-1:0] mf_q;
        logic signed [SUM_W-1:0] mr_q;
        logic signed [SUM_W-1:0] v_up;
        logic signed [INT_W-1:0] res;
        lim_q = $signed(SUM_W'({lim, FRAC_W'(0)}));
        mf_q  = $signed(SUM_W'({mf, FRAC_W'(0)}));
        mr_q  = $signed(SUM_W'({mr, FRAC_W'(0)}));
        v_up  = v + $signed(SUM_W'({FRAC_W{1'b1}}));
        if (v < -lim_q) begin
            res = -$signed(INT_W'(lim));
        end else if (v > lim_q) begin
            res = $signed(INT_W'(lim));
        end else if (v > 0 && v < mf_q) begin
            res = $signed(INT_W'(mf));
        end else if (v < 0 && v > -mr_q) begin
            res = -$signed(INT_W'(mr));
        end else if (v >= 0) begin
            res = v[INT_W+FRAC_W-1:FRAC_W];
        end else begin
            res = v_up[INT_W+FRAC_W-1:FRAC_W];
        end
        return res;
    endfunction

endpackage

[rtl/encoder_pid_motor_controller.sv]
// ============================================================================
// Encoder PID motor controller
// Quadrature position counter with velocity and position-hold PID drive.
// ============================================================================
// One input beat is taken per clock, edge or tick, and the next may follow in
// the very next cycle. An edge beat only steps the position count and gives no
// result. A tick beat, once taken, passes through the input register, position
// stage, error stage, product stage, integral stage and the result register.
// The rate is one beat per cycle while nothing stalls, set by the integral
// add-and-clamp, which closes its loop within a single stage. While a result
// waits on a stalled output the stages behind it keep filling their empty
// slots; the input stalls only once a tick beat cannot move on. Gains and
// minimum drives sit in an APB-style register file and are to be written only
// while the block is idle.
module encoder_pid_motor_controller #(
    parameter int unsigned DUTY_MAX       = 255,
    parameter int unsigned POSITION_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Item channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_cmd,
    input  logic                                i_phase_a,
    input  logic                                i_phase_b,
    input  logic signed [epmc_pkg::GOAL_W-1:0]  i_goal_velocity,
    // Result channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [epmc_pkg::DUTY_W-1:0]         o_forward_duty,
    output logic [epmc_pkg::DUTY_W-1:0]         o_reverse_duty,
    output logic signed [epmc_pkg::VEL_W-1:0]   o_measured_velocity,
    output logic signed [epmc_pkg::POSC_W-1:0]  o_position_count,
    output logic                                o_holding_position,
    // Register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [epmc_pkg::ADDR_W-1:0]         paddr,
    input  logic [epmc_pkg::DATA_W-1:0]         pwdata,
    output logic [epmc_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);
    import epmc_pkg::*;

    t_cfg    cfg;
    t_meas   meas;
    logic    meas_valid;
    logic    meas_ready;
    t_result res;

    // Register file
    epmc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Position count and measurement
    epmc_enc #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_enc (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (t_cmd'(i_cmd)),
        .i_phase_a       (i_phase_a),
        .i_phase_b       (i_phase_b),
        .i_goal_velocity (i_goal_velocity),
        .o_meas_valid    (meas_valid),
        .i_meas_ready    (meas_ready),
        .o_meas          (meas)
    );

    // PID pipeline and result register
    epmc_pid #(
        .DUTY_MAX (DUTY_MAX)
    ) u_pid (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_meas_valid (meas_valid),
        .o_meas_ready (meas_ready),
        .i_meas       (meas),
        .i_cfg        (cfg),
        .o_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .o_res        (res)
    );

    assign o_forward_duty      = res.fwd;
    assign o_reverse_duty      = res.rev;
    assign o_measured_velocity = res.meas;
    assign o_position_count    = res.pos_count;
    assign o_holding_position  = res.hold;

endmodule

[rtl/epmc_cfg.sv]
// ============================================================================
// Encoder PID motor controller register block
// APB-style gain and minimum-drive registers with read-back.
// ============================================================================
module epmc_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [epmc_pkg::ADDR_W-1:0] paddr,
    input  logic [epmc_pkg::DATA_W-1:0] pwdata,
    output logic [epmc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output epmc_pkg::t_cfg              o_cfg
);
    import epmc_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_VEL_KP:  n_cfg.vel_kp  = pwdata[GAIN_W-1:0];
                REG_VEL_KI:  n_cfg.vel_ki  = pwdata[GAIN_W-1:0];
                REG_VEL_KD:  n_cfg.vel_kd  = pwdata[GAIN_W-1:0];
                REG_POS_KP:  n_cfg.pos_kp  = pwdata[GAIN_W-1:0];
                REG_POS_KI:  n_cfg.pos_ki  = pwdata[GAIN_W-1:0];
                REG_POS_KD:  n_cfg.pos_kd  = pwdata[GAIN_W-1:0];
                REG_MIN_FWD: n_cfg.min_fwd = pwdata[MIN_W-1:0];
                REG_MIN_REV: n_cfg.min_rev = pwdata[MIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read-back mux
    always_comb begin
        case (reg_idx)
            REG_VEL_KP:  prdata = DATA_W'(r_cfg.vel_kp);
            REG_VEL_KI:  prdata = DATA_W'(r_cfg.vel_ki);
            REG_VEL_KD:  prdata = DATA_W'(r_cfg.vel_kd);
            REG_POS_KP:  prdata = DATA_W'(r_cfg.pos_kp);
            REG_POS_KI:  prdata = DATA_W'(r_cfg.pos_ki);
            REG_POS_KD:  prdata = DATA_W'(r_cfg.pos_kd);
            REG_MIN_FWD: prdata = DATA_W'(r_cfg.min_fwd);
            REG_MIN_REV: prdata = DATA_W'(r_cfg.min_rev);
            default:     prdata = '0;
        endcase
    end

endmodule

[rtl/epmc_enc.sv]
// ============================================================================
// Encoder PID motor controller position stage
// Input register, quadrature position count, velocity and hold error.
// ============================================================================
`include "encoder_pid_motor_controller_assert.svh"

module epmc_enc #(
    parameter int unsigned POSITION_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  epmc_pkg::t_cmd                     i_cmd,
    input  logic                               i_phase_a,
    input  logic                               i_phase_b,
    input  logic signed [epmc_pkg::GOAL_W-1:0] i_goal_velocity,
    output logic                               o_meas_valid,
    input  logic                               i_meas_ready,
    output epmc_pkg::t_meas                    o_meas
);
    import epmc_pkg::*;

    localparam int unsigned EXT_W =
        (POSITION_WIDTH > POSC_W) ? POSITION_WIDTH : POSC_W + 1;
    localparam logic signed [EXT_W-1:0] VEL_HI  = EXT_W'({1'b0, {(VEL_W-1){1'b1}}});
    localparam logic signed [EXT_W-1:0] VEL_LO  = ~VEL_HI;
    localparam logic signed [EXT_W-1:0] PERR_HI = EXT_W'({1'b0, {(PERR_W-1){1'b1}}});
    localparam logic signed [EXT_W-1:0] PERR_LO = ~PERR_HI;

    // Input register
    logic                     r_in_valid;
    t_cmd                     r_cmd;
    logic                     r_phase_a;
    logic                     r_phase_b;
    logic signed [GOAL_W-1:0] r_goal;

    // Position state
    logic [POSITION_WIDTH-1:0] r_position;
    logic [POSITION_WIDTH-1:0] r_prev_pos;
    logic [POSITION_WIDTH-1:0] r_hold_target;
    logic                      r_latch_pending;
    logic [POSITION_WIDTH-1:0] n_position;

    // Output stage
    logic  r_meas_valid;
    t_meas r_meas;
    t_meas n_meas;

    logic                      in_tick;
    logic                      in_hold;
    logic                      s1_ready;
    logic                      take;
    logic                      tick_take;
    logic                      edge_take;
    logic [POSITION_WIDTH-1:0] vel_diff;
    logic [POSITION_WIDTH-1:0] target_eff;
    logic [POSITION_WIDTH-1:0] hold_diff;
    logic signed [EXT_W-1:0]   vel_ext;
    logic signed [EXT_W-1:0]   perr_ext;
    logic signed [EXT_W-1:0]   pos_ext;

    // Handshake: edge beats retire here, tick beats need room downstream
    assign in_tick   = (r_cmd == CMD_TICK);
    assign in_hold   = (r_goal == '0);
    assign s1_ready  = !r_meas_valid || i_meas_ready;
    assign take      = r_in_valid && (!in_tick || s1_ready);
    assign tick_take = take && in_tick;
    assign edge_take = take && !in_tick;
    assign o_ready   = !r_in_valid || take;

    assign o_meas_valid = r_meas_valid;
    assign o_meas       = r_meas;

    // Quadrature step: up when the phases agree
    assign n_position = (r_phase_a == r_phase_b) ? r_position + POSITION_WIDTH'(1)
                                                 : r_position - POSITION_WIDTH'(1);

    // Wrap-aware differences
    assign vel_diff   = r_position - r_prev_pos;
    assign target_eff = r_latch_pending ? r_position : r_hold_target;
    assign hold_diff  = target_eff - r_position;
    assign vel_ext    = EXT_W'($signed(vel_diff));
    assign perr_ext   = EXT_W'($signed(hold_diff));
    assign pos_ext    = EXT_W'($signed(r_position));

    // Tick beat payload with saturation
    always_comb begin
        n_meas.hold      = in_hold;
        n_meas.goal      = r_goal;
        n_meas.pos_count = pos_ext[POSC_W-1:0];
        if (vel_ext > VEL_HI) begin
            n_meas.meas = VEL_HI[VEL_W-1:0];
        end else if (vel_ext < VEL_LO) begin
            n_meas.meas = VEL_LO[VEL_W-1:0];
        end else begin
            n_meas.meas = vel_ext[VEL_W-1:0];
        end
        if (perr_ext > PERR_HI) begin
            n_meas.perr = PERR_HI[PERR_W-1:0];
        end else if (perr_ext < PERR_LO) begin
            n_meas.perr = PERR_LO[PERR_W-1:0];
        end else begin
            n_meas.perr = perr_ext[PERR_W-1:0];
        end
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_meas_valid    <= 1'b0;
            r_position      <= '0;
            r_prev_pos      <= '0;
            r_hold_target   <= '0;
            r_latch_pending <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (s1_ready) begin
                r_meas_valid <= tick_take;
            end
            if (edge_take) begin
                r_position <= n_position;
            end
            if (tick_take) begin
                r_prev_pos <= r_position;
                if (in_hold) begin
                    if (r_latch_pending) begin
                        r_hold_target <= r_position;
                    end
                    r_latch_pending <= 1'b0;
                end else begin
                    r_latch_pending <= 1'b1;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd     <= i_cmd;
            r_phase_a <= i_phase_a;
            r_phase_b <= i_phase_b;
            r_goal    <= i_goal_velocity;
        end
        if (tick_take) begin
            r_meas <= n_meas;
        end
    end

    `EPMC_ASSERT_NEXT(a_edge_moves_position, i_clk, i_rst_n, edge_take,
        r_position != $past(r_position), "edge beat left position unchanged")
    `EPMC_ASSERT_NEXT(a_hold_clears_latch, i_clk, i_rst_n, tick_take && in_hold,
        !r_latch_pending, "hold tick left latch pending")
    `EPMC_ASSERT_NEXT(a_edge_no_result, i_clk, i_rst_n, edge_take && !r_meas_valid,
        !r_meas_valid, "edge beat produced a tick beat")

endmodule

[rtl/epmc_pid.sv]
// ============================================================================
// Encoder PID motor controller PID pipeline
// Error, gain products, integral update and drive clamp in four stages.
// ============================================================================
`include "encoder_pid_motor_controller_assert.svh"

module epmc_pid #(
    parameter int unsigned DUTY_MAX = 255
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_meas_valid,
    output logic              o_meas_ready,
    input  epmc_pkg::t_meas   i_meas,
    input  epmc_pkg::t_cfg    i_cfg,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output epmc_pkg::t_result o_res
);
    import epmc_pkg::*;

    localparam logic [LIM_W-1:0] DUTY_LIM = LIM_W'(DUTY_MAX);
    localparam int unsigned LIFT_MAX  = (1 << MIN_W) - 1;
    localparam int unsigned INT_BOUND = (DUTY_MAX > LIFT_MAX) ? DUTY_MAX : LIFT_MAX;
    localparam logic signed [INT_W-1:0] INT_HI  = INT_W'(INT_BOUND);
    localparam logic signed [INT_W-1:0] INT_LO  = -INT_HI;
    localparam logic signed [INT_W-1:0] DUTY_HI = INT_W'({DUTY_W{1'b1}});
    localparam logic signed [VERR_W:0]  VERR_HI = {2'b00, {(VERR_W-1){1'b1}}};
    localparam logic signed [VERR_W:0]  VERR_LO = ~VERR_HI;

    typedef struct packed {
        logic                     hold;
        logic signed [PERR_W-1:0] err;
        logic signed [VERR_W:0]   diff;
        logic signed [VEL_W-1:0]  meas;
        logic [POSC_W-1:0]        pos_count;
    } t_err_stage;

    typedef struct packed {
        logic                     hold;
        logic signed [PROD_W-1:0] p_p;
        logic signed [PROD_W-1:0] p_i;
        logic signed [PROD_W-1:0] p_d;
        logic signed [VEL_W-1:0]  meas;
        logic [POSC_W-1:0]        pos_count;
    } t_prod_stage;

    typedef struct packed {
        logic                    hold;
        logic signed [SUM_W-1:0] pd_sum;
        logic signed [INT_W-1:0] integ;
        logic signed [VEL_W-1:0] meas;
        logic [POSC_W-1:0]       pos_count;
    } t_sum_stage;

    // Position gains carry an extra Q8 step, velocity errors are Q8 already
    function automatic logic signed [SUM_W-1:0] scale_prod(
        input logic                     hold,
        input logic signed [PROD_W-1:0] p
    );
        return hold ? SUM_W'($signed({p, GAIN_FRAC'(0)})) : SUM_W'(p);
    endfunction

    // Stage registers and loop state
    logic        r_a_valid, r_b_valid, r_c_valid, r_res_valid;
    t_err_stage  r_a, n_a;
    t_prod_stage r_b, n_b;
    t_sum_stage  r_c, n_c;
    t_result     r_res, n_res;
    logic signed [VERR_W-1:0] r_vel_last_err;
    logic signed [INT_W-1:0]  r_vel_int;

    logic rdy_a, rdy_b, rdy_c, rdy_d;
    logic take_a, take_b, take_c, take_d;

    logic signed [VERR_W:0]   goal_ext;
    logic signed [VERR_W:0]   meas_q;
    logic signed [VERR_W:0]   verr_raw;
    logic signed [VERR_W-1:0] verr;
    logic [GAIN_W-1:0]        kp_sel, ki_sel, kd_sel;
    logic signed [PERR_W-1:0] d_opnd;
    logic signed [PROD_W:0]   mul_p, mul_i, mul_d;
    logic signed [SUM_W-1:0]  int_base, int_sum;
    logic signed [INT_W-1:0]  int_new;
    logic signed [SUM_W-1:0]  drv_sum;
    logic signed [INT_W-1:0]  drive;
    logic signed [INT_W-1:0]  drive_neg;

    // Pipeline flow: a stage moves when the next one is empty or moving
    assign rdy_d  = !r_res_valid || i_res_ready;
    assign rdy_c  = !r_c_valid || rdy_d;
    assign rdy_b  = !r_b_valid || rdy_c;
    assign rdy_a  = !r_a_valid || rdy_b;
    assign take_a = i_meas_valid && rdy_a;
    assign take_b = r_a_valid && rdy_b;
    assign take_c = r_b_valid && rdy_c;
    assign take_d = r_c_valid && rdy_d;

    assign o_meas_ready = rdy_a;
    assign o_res_valid  = r_res_valid;
    assign o_res        = r_res;

    // Stage A: velocity error in Q16.8 and its change
    always_comb begin
        goal_ext = (VERR_W+1)'(i_meas.goal);
        meas_q   = $signed({i_meas.meas[VEL_W-1], i_meas.meas, GAIN_FRAC'(0)});
        verr_raw = goal_ext - meas_q;
        if (verr_raw > VERR_HI) begin
            verr = VERR_HI[VERR_W-1:0];
        end else if (verr_raw < VERR_LO) begin
            verr = VERR_LO[VERR_W-1:0];
        end else begin
            verr = verr_raw[VERR_W-1:0];
        end
        n_a.hold      = i_meas.hold;
        n_a.err       = i_meas.hold ? i_meas.perr : PERR_W'(verr);
        n_a.diff      = (VERR_W+1)'(verr) - (VERR_W+1)'(r_vel_last_err);
        n_a.meas      = i_meas.meas;
        n_a.pos_count = i_meas.pos_count;
    end

    // Stage B: the three gain products
    always_comb begin
        kp_sel = r_a.hold ? i_cfg.pos_kp : i_cfg.vel_kp;
        ki_sel = r_a.hold ? i_cfg.pos_ki : i_cfg.vel_ki;
        kd_sel = r_a.hold ? i_cfg.pos_kd : i_cfg.vel_kd;
        d_opnd = r_a.hold ? r_a.err : PERR_W'(r_a.diff);
        mul_p  = r_a.err * $signed({1'b0, kp_sel});
        mul_i  = r_a.err * $signed({1'b0, ki_sel});
        mul_d  = d_opnd * $signed({1'b0, kd_sel});
        n_b.hold      = r_a.hold;
        n_b.p_p       = mul_p[PROD_W-1:0];
        n_b.p_i       = mul_i[PROD_W-1:0];
        n_b.p_d       = mul_d[PROD_W-1:0];
        n_b.meas      = r_a.meas;
        n_b.pos_count = r_a.pos_count;
    end

    // Stage C: integral update (hold mode starts from a cleared integral)
    always_comb begin
        int_base = r_b.hold ? SUM_W'(0) : SUM_W'($signed({r_vel_int, FRAC_W'(0)}));
        int_sum  = int_base + scale_prod(r_b.hold, r_b.p_i);
        int_new  = clamp_drive(int_sum, DUTY_LIM, i_cfg.min_fwd, i_cfg.min_rev);
        n_c.hold      = r_b.hold;
        n_c.pd_sum    = scale_prod(r_b.hold, r_b.p_p) + scale_prod(r_b.hold, r_b.p_d);
        n_c.integ     = int_new;
        n_c.meas      = r_b.meas;
        n_c.pos_count = r_b.pos_count;
    end

    // Stage D: drive clamp and split into bridge duties
    always_comb begin
        drv_sum   = r_c.pd_sum + SUM_W'($signed({r_c.integ, FRAC_W'(0)}));
        drive     = clamp_drive(drv_sum, DUTY_LIM, i_cfg.min_fwd, i_cfg.min_rev);
        drive_neg = -drive;
        n_res.fwd = '0;
        n_res.rev = '0;
        if (drive > 0) begin
            n_res.fwd = (drive > DUTY_HI) ? {DUTY_W{1'b1}} : drive[DUTY_W-1:0];
        end else if (drive < 0) begin
            n_res.rev = (drive_neg > DUTY_HI) ? {DUTY_W{1'b1}} : drive_neg[DUTY_W-1:0];
        end
        n_res.meas      = r_c.meas;
        n_res.pos_count = r_c.pos_count;
        n_res.hold      = r_c.hold;
    end

    // Valid bits and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid      <= 1'b0;
            r_b_valid      <= 1'b0;
            r_c_valid      <= 1'b0;
            r_res_valid    <= 1'b0;
            r_vel_last_err <= '0;
            r_vel_int      <= '0;
        end else begin
            if (rdy_a) begin
                r_a_valid <= i_meas_valid;
            end
            if (rdy_b) begin
                r_b_valid <= r_a_valid;
            end
            if (rdy_c) begin
                r_c_valid <= r_b_valid;
            end
            if (rdy_d) begin
                r_res_valid <= r_c_valid;
            end
            if (take_a) begin
                r_vel_last_err <= i_meas.hold ? '0 : verr;
            end
            if (take_c) begin
                r_vel_int <= r_b.hold ? '0 : int_new;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (take_a) begin
            r_a <= n_a;
        end
        if (take_b) begin
            r_b <= n_b;
        end
        if (take_c) begin
            r_c <= n_c;
        end
        if (take_d) begin
            r_res <= n_res;
        end
    end

    `EPMC_ASSERT_NOW(a_one_direction, i_clk, i_rst_n, r_res_valid,
        (r_res.fwd == '0) || (r_res.rev == '0), "both bridge duties nonzero")
    `EPMC_ASSERT_NEXT(a_hold_clears_integral, i_clk, i_rst_n, take_c && r_b.hold,
        r_vel_int == '0, "hold beat left velocity integral set")
    `EPMC_ASSERT_NEXT(a_hold_clears_last_err, i_clk, i_rst_n, take_a && i_meas.hold,
        r_vel_last_err == '0, "hold beat left velocity error set")
    `EPMC_ASSERT_NOW(a_integral_bounded, i_clk, i_rst_n, 1'b1,
        (r_vel_int <= INT_HI) && (r_vel_int >= INT_LO), "integral beyond clamp range")

endmodule

[tb/sv/tb_encoder_pid_motor_controller.sv]
`timescale 1ns / 1ps
// ============================================================================
// Encoder PID motor controller testbench
// Drives encoder edge and control tick beats with random gaps and the gains
// over the register port. A local predictor tracks the position count, the
// velocity and hold loops and the drive clamp, and every result beat is
// compared field by field with its expectation. The sweep covers the directed
// corners, random edge runs ended by ticks, several gain settings, one long
// output stall with back-to-back ticks behind it, and back-to-back edge bursts
// in both directions.
// ============================================================================
module tb_encoder_pid_motor_controller;
    import epmc_pkg::*;

    localparam longint Q16            = 65536;
    localparam longint DUTY_CEIL      = 255;
    localparam int     SETTLE_CYCLES  = 12;
    localparam int     STALL_AT       = 12;
    localparam int     STALL_CYCLES   = 300;
    localparam int     PRESSURE_PAIRS = 24;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     BURST_UP       = 40;
    localparam int     BURST_DOWN     = 70;

    typedef struct {
        t_cmd               cmd;
        logic               pha;
        logic               phb;
        logic signed [15:0] goal;
        int unsigned        gap;
    } enc_beat_t;

    // Block ports
    logic                       i_clk           = 1'b0;
    logic                       i_rst_n         = 1'b0;
    logic                       i_valid         = 1'b0;
    logic                       o_ready;
    t_cmd                       i_cmd           = CMD_EDGE;
    logic                       i_phase_a       = 1'b0;
    logic                       i_phase_b       = 1'b0;
    logic signed [GOAL_W-1:0]   i_goal_velocity = '0;
    logic                       o_valid;
    logic                       i_ready         = 1'b0;
    logic [DUTY_W-1:0]          o_forward_duty;
    logic [DUTY_W-1:0]          o_reverse_duty;
    logic signed [VEL_W-1:0]    o_measured_velocity;
    logic signed [POSC_W-1:0]   o_position_count;
    logic                       o_holding_position;
    logic                       psel            = 1'b0;
    logic                       penable         = 1'b0;
    logic                       pwrite          = 1'b0;
    logic [ADDR_W-1:0]          paddr           = '0;
    logic [DATA_W-1:0]          pwdata          = '0;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;

    // Stimulus and scoreboard
    enc_beat_t   beat_queue[$];
    t_result     expected_q[$];
    enc_beat_t   cur_beat;
    logic        have_beat    = 1'b0;
    int unsigned tx_wait      = 0;
    logic        tx_calm      = 1'b0;
    int          n_queued     = 0;
    int          n_accepted   = 0;
    int          n_results    = 0;
    int unsigned rx_wait      = 0;
    int unsigned rx_hold;
    logic        rx_calm      = 1'b0;
    logic        mismatch_seen = 1'b0;
    int          idle_cycles  = 0;
    t_result     want;

    // Predictor state
    longint      gain_reg [8] = '{default: 0};
    logic [31:0] enc_position       = '0;
    logic [31:0] last_tick_position = '0;
    logic [31:0] hold_pos           = '0;
    logic        relatch            = 1'b0;
    longint      vel_integ          = 0;
    longint      vel_prev_err       = 0;

    encoder_pid_motor_controller dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_cmd               (i_cmd),
        .i_phase_a           (i_phase_a),
        .i_phase_b           (i_phase_b),
        .i_goal_velocity     (i_goal_velocity),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_forward_duty      (o_forward_duty),
        .o_reverse_duty      (o_reverse_duty),
        .o_measured_velocity (o_measured_velocity),
        .o_position_count    (o_position_count),
        .o_holding_position  (o_holding_position),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    // Clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Drive clamp on a Q.16 value: limit, lift to min drive, else truncate
    function automatic longint limit_drive(longint v);
        longint lim_q;
        longint fwd_q;
        longint rev_q;
        lim_q = DUTY_CEIL * Q16;
        fwd_q = gain_reg[REG_MIN_FWD] * Q16;
        rev_q = gain_reg[REG_MIN_REV] * Q16;
        if (v < -lim_q) return -DUTY_CEIL;
        if (v > lim_q) return DUTY_CEIL;
        if (v > 0 && v < fwd_q) return gain_reg[REG_MIN_FWD];
        if (v < 0 && v > -rev_q) return -gain_reg[REG_MIN_REV];
        return v / Q16;
    endfunction

    // Edge: up when the phases agree, down otherwise
    function automatic void step_encoder(logic pha, logic phb);
        if (pha == phb) enc_position = enc_position + 32'd1;
        else enc_position = enc_position - 32'd1;
    endfunction

    // Tick: measure velocity, run the velocity or hold loop, split the drive
    function automatic t_result predict_tick(logic signed [15:0] goal);
        logic [31:0] moved;
        logic [31:0] gap_to_target;
        longint      meas;
        longint      err;
        longint      slope;
        longint      hold_integ;
        longint      drive;
        t_result     r;
        moved = enc_position - last_tick_position;
        meas  = longint'($signed(moved));
        if (meas > 32767) meas = 32767;
        else if (meas < -32768) meas = -32768;
        last_tick_position = enc_position;
        if (goal != 0) begin
            err = longint'(goal) - meas * 256;
            if (err > 8388607) err = 8388607;
            else if (err < -8388608) err = -8388608;
            vel_integ = limit_drive(vel_integ * Q16 + err * gain_reg[REG_VEL_KI]);
            slope = (err - vel_prev_err) * gain_reg[REG_VEL_KD];
            vel_prev_err = err;
            drive = limit_drive(err * gain_reg[REG_VEL_KP] + vel_integ * Q16 + slope);
            relatch = 1'b1;
            r.hold = 1'b0;
        end else begin
            // latch once per entry into hold; integrals and last errors start clear
            if (relatch) begin
                hold_pos = enc_position;
                relatch  = 1'b0;
            end
            vel_integ     = 0;
            vel_prev_err  = 0;
            gap_to_target = hold_pos - enc_position;
            err           = longint'($signed(gap_to_target));
            hold_integ    = limit_drive(err * gain_reg[REG_POS_KI] * 256);
            slope         = err * gain_reg[REG_POS_KD] * 256;
            drive = limit_drive(err * gain_reg[REG_POS_KP] * 256 + hold_integ * Q16 + slope);
            r.hold = 1'b1;
        end
        r.fwd = '0;
        r.rev = '0;
        if (drive > 0) r.fwd = DUTY_W'(drive > DUTY_CEIL ? DUTY_CEIL : drive);
        if (drive < 0) r.rev = DUTY_W'(-drive > DUTY_CEIL ? DUTY_CEIL : -drive);
        r.meas      = VEL_W'(meas);
        r.pos_count = enc_position;
        return r;
    endfunction

    function automatic int unsigned next_gap();
        return tx_calm ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic logic signed [15:0] pick_goal();
        case ($urandom_range(0, 9))
            0, 1, 2: return 16'sd0;
            3: begin
                case ($urandom_range(0, 3))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sd1;
                    default: return -16'sd1;
                endcase
            end
            4: return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    task automatic queue_beat(t_cmd c, logic pha, logic phb, logic signed [15:0] goal,
                              int unsigned gap);
        enc_beat_t b;
        b.cmd  = c;
        b.pha  = pha;
        b.phb  = phb;
        b.goal = goal;
        b.gap  = gap;
        beat_queue.push_back(b);
        n_queued++;
    endtask

    // Register write: setup then access, waiting on pready
    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MIN_FWD || idx == REG_MIN_REV) gain_reg[idx] = longint'(value & 32'hFF);
        else gain_reg[idx] = longint'(value & 32'hFFFF);
    endtask

    task automatic load_gains(logic [31:0] vkp, logic [31:0] vki, logic [31:0] vkd,
                              logic [31:0] pkp, logic [31:0] pki, logic [31:0] pkd,
                              logic [31:0] mfwd, logic [31:0] mrev);
        write_reg(REG_VEL_KP, vkp);
        write_reg(REG_VEL_KI, vki);
        write_reg(REG_VEL_KD, vkd);
        write_reg(REG_POS_KP, pkp);
        write_reg(REG_POS_KI, pki);
        write_reg(REG_POS_KD, pkd);
        write_reg(REG_MIN_FWD, mfwd);
        write_reg(REG_MIN_REV, mrev);
    endtask

    // Random edge runs, each closed by a tick
    task automatic random_run(int n_items);
        int   made;
        int   n_edges;
        int   dir;
        logic a;
        made = 0;
        while (made < n_items) begin
            if ($urandom_range(0, 9) == 0) tx_calm = !tx_calm;
            n_edges = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 120)
                                                  : $urandom_range(0, 12);
            dir = $urandom_range(0, 2);
            for (int k = 0; k < n_edges; k++) begin
                a = 1'($urandom);
                queue_beat(CMD_EDGE, a, (dir == 0) ? a : (dir == 1) ? !a : 1'($urandom),
                           16'($urandom), next_gap());
            end
            queue_beat(CMD_TICK, 1'($urandom), 1'($urandom), pick_goal(), next_gap());
            made += n_edges + 1;
        end
    endtask

    // Wait until every beat is taken and every result is back
    task automatic settle();
        while (n_accepted != n_queued || expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic compare_field(string what, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h",
                     $time, what, exp_v, got_v);
            mismatch_seen = 1'b1;
        end
    endtask

    // Driver: offer the next beat after its gap, hold it until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            have_beat = 1'b0;
            tx_wait   = 0;
        end else begin
            if (i_valid && o_ready) begin
                if (i_cmd == CMD_EDGE) step_encoder(i_phase_a, i_phase_b);
                else expected_q.push_back(predict_tick(i_goal_velocity));
                n_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (!have_beat && beat_queue.size() > 0) begin
                    cur_beat  = beat_queue.pop_front();
                    tx_wait   = cur_beat.gap;
                    have_beat = 1'b1;
                end
                if (have_beat && tx_wait == 0) begin
                    i_valid         <= 1'b1;
                    i_cmd           <= cur_beat.cmd;
                    i_phase_a       <= cur_beat.pha;
                    i_phase_b       <= cur_beat.phb;
                    i_goal_velocity <= cur_beat.goal;
                    have_beat = 1'b0;
                end else begin
                    if (have_beat) tx_wait--;
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result beat, then draw the next ready gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_wait <= 0;
        end else if (o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t ns: result beat, expected none, actual fwd %0d rev %0d pos %0h",
                         $time, o_forward_duty, o_reverse_duty, o_position_count);
                mismatch_seen = 1'b1;
            end else begin
                want = expected_q.pop_front();
                compare_field("forward_duty", 32'(want.fwd), 32'(o_forward_duty));
                compare_field("reverse_duty", 32'(want.rev), 32'(o_reverse_duty));
                compare_field("measured_velocity", 32'(want.meas), 32'(o_measured_velocity));
                compare_field("position_count", 32'(want.pos_count), 32'(o_position_count));
                compare_field("holding_position", 32'(want.hold), 32'(o_holding_position));
            end
            n_results++;
            if (n_results % 20 == 0) rx_calm = ($urandom_range(0, 3) == 0);
            rx_hold = rx_calm ? 0 : $urandom_range(0, 11);
            // one long hold-off so the pipeline backs up into the input
            if (n_results == STALL_AT) rx_hold = STALL_CYCLES;
            rx_wait <= rx_hold;
            i_ready <= (rx_hold == 0);
        end else if (rx_wait > 1) begin
            rx_wait <= rx_wait - 1;
        end else begin
            rx_wait <= 0;
            i_ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no beat taken on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Sequence of phases
    initial begin
        logic a;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners
        load_gains(32'h0100, 32'h0040, 32'h0020, 32'h0200, 32'h0010, 32'h0008, 10, 12);
        queue_beat(CMD_EDGE, 1'b0, 1'b0, 16'sh7FFF, next_gap());
        queue_beat(CMD_EDGE, 1'b1, 1'b1, 16'sh8000, next_gap());
        queue_beat(CMD_EDGE, 1'b1, 1'b1, 16'sd0, next_gap());
        queue_beat(CMD_EDGE, 1'b0, 1'b1, 16'shFFFF, next_gap());
        queue_beat(CMD_EDGE, 1'b1, 1'b0, 16'sd0, next_gap());
        queue_beat(CMD_EDGE, 1'b0, 1'b0, 16'sd0, next_gap());
        queue_beat(CMD_EDGE, 1'b1, 1'b1, 16'sd0, next_gap());
        // hold straight from reset: target stays at zero
        queue_beat(CMD_TICK, 1'b1, 1'b0, 16'sd0, next_gap());
        queue_beat(CMD_TICK, 1'b0, 1'b1, 16'sh7FFF, next_gap());
        queue_beat(CMD_TICK, 1'b1, 1'b1, 16'sh8000, next_gap());
        queue_beat(CMD_TICK, 1'b0, 1'b0, 16'sd1, next_gap());
        queue_beat(CMD_TICK, 1'b0, 1'b0, -16'sd1, next_gap());
        queue_beat(CMD_EDGE, 1'b1, 1'b0, 16'sd0, next_gap());
        queue_beat(CMD_EDGE, 1'b0, 1'b1, 16'sd0, next_gap());
        // entry into hold latches the target, a second zero goal keeps it
        queue_beat(CMD_TICK, 1'b0, 1'b0, 16'sd0, next_gap());
        queue_beat(CMD_EDGE, 1'b1, 1'b1, 16'sd0, next_gap());
        queue_beat(CMD_EDGE, 1'b0, 1'b0, 16'sd0, next_gap());
        queue_beat(CMD_TICK, 1'b0, 1'b0, 16'sd0, next_gap());
        queue_beat(CMD_TICK, 1'b0, 1'b0, 16'sd0, next_gap());
        queue_beat(CMD_TICK, 1'b0, 1'b0, 16'sd256, next_gap());
        settle();

        // Back-to-back edges and ticks; the long output stall lands in here
        for (int k = 0; k < PRESSURE_PAIRS; k++) begin
            a = 1'($urandom);
            queue_beat(CMD_EDGE, a, 1'($urandom), 16'($urandom), 0);
            queue_beat(CMD_TICK, 1'b0, 1'b0, pick_goal(), 0);
        end
        settle();

        // Small gains, random min drives
        load_gains($urandom_range(0, 512), $urandom_range(0, 512), $urandom_range(0, 512),
                   $urandom_range(0, 512), $urandom_range(0, 512), $urandom_range(0, 512),
                   $urandom_range(0, 16), $urandom_range(0, 16));
        random_run(320);
        settle();

        // Everything at its top
        load_gains(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 255, 255);
        random_run(280);
        settle();

        // Everything cleared
        load_gains(0, 0, 0, 0, 0, 0, 0, 0);
        random_run(200);
        settle();

        // Full-range random setting
        load_gains($urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 255), $urandom_range(0, 255));
        random_run(320);
        settle();

        // Small gains, no minimum drive lift
        load_gains($urandom_range(0, 256), $urandom_range(0, 256), $urandom_range(0, 256),
                   $urandom_range(0, 64), $urandom_range(0, 64), $urandom_range(0, 64), 0, 0);
        random_run(320);
        settle();

        // Back-to-back edge bursts up and down, then hold and velocity ticks
        load_gains($urandom_range(0, 512), $urandom_range(0, 512), $urandom_range(0, 512),
                   $urandom_range(0, 512), $urandom_range(0, 512), $urandom_range(0, 512),
                   $urandom_range(0, 32), $urandom_range(0, 32));
        for (int k = 0; k < BURST_UP; k++) begin
            a = 1'($urandom);
            queue_beat(CMD_EDGE, a, a, 16'($urandom), 0);
        end
        queue_beat(CMD_TICK, 1'b0, 1'b0, 16'sd0, 0);
        for (int k = 0; k < BURST_DOWN; k++) begin
            a = 1'($urandom);
            queue_beat(CMD_EDGE, a, !a, 16'($urandom), 0);
        end
        queue_beat(CMD_TICK, 1'b1, 1'b1, 16'sd0, 0);
        queue_beat(CMD_TICK, 1'b0, 1'b1, 16'sh7FFF, 0);
        random_run(200);
        settle();

        if (!mismatch_seen && expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
